>>> hdl/fragment_reassembly_table_assert.svh
// Assertion macros used by the reassembly table controller.
`ifndef FRAGMENT_REASSEMBLY_TABLE_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FRA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fragment_reassembly_table: assertion failed");

// Next-cycle implication, disabled during reset.
`define FRA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fragment_reassembly_table: assertion failed");

`endif

>>> hdl/fra_pkg.sv
`default_nettype none
package fra_pkg;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_DELETE = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_DUP        = 3'd1,
      STS_FULL       = 3'd2,
      STS_NOTFOUND   = 3'd3,
      STS_INCOMPLETE = 3'd4,
      STS_FLUSHED    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MODE_FREE    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_DONE    = 2'd2
   } mode_type;

   typedef enum logic {
      CSR_HEADER_LEN    = 1'b0,
      CSR_ITEM_OVERHEAD = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_CLAIM,
      ST_SRCH,
      ST_INS_CHK,
      ST_INS_SHIFT,
      ST_INS_WR,
      ST_DEL_SHIFT,
      ST_SEL,
      ST_FL_RD,
      ST_FL_EMIT,
      ST_RESP
   } state_type;

   // One stored fragment
   typedef struct packed {
      logic [31:0] id;
      logic [15:0] len;
   } entry_type;

   // Write side of the fragment store
   typedef struct packed {
      logic      en;
      entry_type data;
   } mem_wr_type;

   localparam logic [15:0] HEADER_LEN_RESET    = 16'd16;
   localparam logic [15:0] ITEM_OVERHEAD_RESET = 16'd8;

endpackage
`default_nettype wire

>>> hdl/fra_channels.sv
`default_nettype none
// Request channel
interface fra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] frag_id;
   logic [15:0] data_len;
   logic [1:0]  slot_sel;
   logic [31:0] time_now;

   modport source (output valid, opcode, frag_id, data_len, slot_sel, time_now,
                   input ready);
   modport sink   (input valid, opcode, frag_id, data_len, slot_sel, time_now,
                   output ready);
endinterface

// Response channel
interface fra_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  slot;
   logic        evicted;
   logic [31:0] entry_id;
   logic [15:0] entry_len;
   logic [5:0]  list_count;
   logic [31:0] msg_total;
   logic [1:0]  slot_mode;
   logic        last;

   modport source (output valid, status, slot, evicted, entry_id, entry_len, list_count,
                   msg_total, slot_mode, last, input ready);
   modport sink   (input valid, status, slot, evicted, entry_id, entry_len, list_count,
                   msg_total, slot_mode, last, output ready);
endinterface
`default_nettype wire

>>> hdl/fra_entry_mem.sv
`default_nettype none
module fra_entry_mem import fra_pkg::*; #(
   parameter int SLOTS = 4,
   parameter int ENTRIES = 32,
   localparam int AW = $clog2(SLOTS * ENTRIES)
) (
   input  wire logic       clock,
   input  wire mem_wr_type mem_wr,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [AW-1:0] rd_addr,
   output      entry_type  rd_data
);

   entry_type mem_ff [SLOTS*ENTRIES];
   entry_type rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem_ff[wr_addr] <= mem_wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/fra_ctrl.sv
`default_nettype none
`include "fragment_reassembly_table_assert.svh"
module fra_ctrl import fra_pkg::*; #(
   parameter int SLOTS = 4,
   parameter int ENTRIES = 32,
   localparam int AW = $clog2(SLOTS * ENTRIES)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] header_len,
   input  wire logic [15:0] item_overhead,
   fra_req_if.sink          req,
   fra_rsp_if.source        rsp,
   output      mem_wr_type  mem_wr,
   output      logic [AW-1:0] mem_waddr,
   output      logic [AW-1:0] mem_raddr,
   input  wire entry_type   mem_rdata
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   // Latched transaction
   opcode_type  op_ff, op_in;
   logic [31:0] id_ff, id_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [1:0]  sel_ff, sel_in;
   logic [31:0] now_ff, now_in;

   // Slot scan
   logic [SW-1:0] sidx_ff, sidx_in;
   logic [SW-1:0] coll_ff, coll_in, free_ff, free_in, best_ff, best_in;
   logic          found_coll_ff, found_coll_in, found_free_ff, found_free_in;
   logic [31:0]   besttime_ff, besttime_in;
   logic          evict_ff, evict_in;
   logic          slot_ok_ff, slot_ok_in;
   status_type    status_ff, status_in;

   // Entry walk
   logic [CW-1:0] n_ff, n_in, k_ff, k_in, pos_ff, pos_in, tag_ff, tag_in;
   logic          vld_ff, vld_in;

   // Slot table
   mode_type    mode_ff [SLOTS];
   mode_type    mode_in [SLOTS];
   logic [7:0]  file_ff [SLOTS];
   logic [7:0]  file_in [SLOTS];
   logic [31:0] time_ff [SLOTS];
   logic [31:0] time_in [SLOTS];
   logic [CW-1:0] cnt_ff [SLOTS];
   logic [CW-1:0] cnt_in [SLOTS];
   logic [31:0] len_ff [SLOTS];
   logic [31:0] len_in [SLOTS];

   // Response register
   logic        ovld_ff, ovld_in;
   status_type  o_status_ff, o_status_in;
   logic [1:0]  o_slot_ff, o_slot_in;
   logic        o_evicted_ff, o_evicted_in;
   logic [31:0] o_id_ff, o_id_in;
   logic [15:0] o_len_ff, o_len_in;
   logic [5:0]  o_count_ff, o_count_in;
   logic [31:0] o_total_ff, o_total_in;
   mode_type    o_mode_ff, o_mode_in;
   logic        o_last_ff, o_last_in;

   // Shared helpers
   logic          accept, out_free, sidx_last, sel_valid;
   logic          rd_eq, rd_gt, rd_end;
   logic [AW-1:0] base;
   mode_type      cur_mode;
   logic [CW-1:0] cur_cnt, new_cnt;
   logic          claim_new;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !ovld_ff || rsp.ready;
   assign sidx_last = (sidx_ff == SW'(SLOTS - 1));
   assign sel_valid = (int'(sel_ff) < SLOTS);
   assign cur_mode  = mode_ff[sidx_ff];
   assign cur_cnt   = cnt_ff[sidx_ff];
   assign base      = AW'(sidx_ff) * AW'(ENTRIES);
   assign new_cnt   = n_ff + CW'(1);
   assign claim_new = evict_ff || (cur_mode == MODE_FREE);
   // Shared compare unit on the entry read back from the store
   assign rd_eq  = vld_ff && (mem_rdata.id == id_ff);
   assign rd_gt  = vld_ff && (mem_rdata.id > id_ff);
   assign rd_end = vld_ff && !rd_eq && !rd_gt && (tag_ff + CW'(1) == n_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req.opcode))
                  OP_PUSH, OP_DELETE: state_in = ST_SCAN;
                  default:            state_in = ST_SEL;
               endcase
            end
         end
         ST_SCAN: begin
            if (sidx_last) state_in = ST_PICK;
         end
         ST_PICK: begin
            if (op_ff == OP_PUSH || found_coll_ff) state_in = ST_CLAIM;
            else state_in = ST_RESP;
         end
         ST_CLAIM: begin
            if (claim_new || cur_cnt == '0) begin
               state_in = (op_ff == OP_PUSH) ? ST_INS_CHK : ST_RESP;
            end else begin
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (rd_eq) begin
               state_in = (op_ff == OP_PUSH) ? ST_RESP : ST_DEL_SHIFT;
            end else if (rd_gt || rd_end) begin
               state_in = (op_ff == OP_PUSH) ? ST_INS_CHK : ST_RESP;
            end
         end
         ST_INS_CHK: begin
            if (n_ff >= CW'(ENTRIES)) state_in = ST_RESP;
            else if (pos_ff == n_ff) state_in = ST_INS_WR;
            else state_in = ST_INS_SHIFT;
         end
         ST_INS_SHIFT: begin
            if (k_ff == pos_ff) state_in = ST_INS_WR;
         end
         ST_INS_WR:    state_in = ST_RESP;
         ST_DEL_SHIFT: begin
            if (k_ff == n_ff) state_in = ST_RESP;
         end
         ST_SEL: begin
            if (sel_valid && op_ff == OP_FLUSH && cur_mode == MODE_DONE && cur_cnt != '0) begin
               state_in = ST_FL_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FL_RD:   state_in = ST_FL_EMIT;
         ST_FL_EMIT: begin
            if (out_free) state_in = (k_ff + CW'(1) == n_ff) ? ST_IDLE : ST_FL_RD;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      op_in = op_ff; id_in = id_ff; dlen_in = dlen_ff; sel_in = sel_ff; now_in = now_ff;
      sidx_in = sidx_ff; coll_in = coll_ff; free_in = free_ff; best_in = best_ff;
      found_coll_in = found_coll_ff; found_free_in = found_free_ff;
      besttime_in = besttime_ff; evict_in = evict_ff; slot_ok_in = slot_ok_ff;
      status_in = status_ff;
      n_in = n_ff; k_in = k_ff; pos_in = pos_ff; tag_in = tag_ff; vld_in = vld_ff;
      mode_in = mode_ff; file_in = file_ff; time_in = time_ff; cnt_in = cnt_ff;
      len_in = len_ff;
      mem_wr.en   = 1'b0;
      mem_wr.data = mem_rdata;
      mem_waddr   = base + AW'(tag_ff);
      mem_raddr   = base + AW'(k_ff);
      ovld_in = ovld_ff && !rsp.ready;
      o_status_in = o_status_ff; o_slot_in = o_slot_ff; o_evicted_in = o_evicted_ff;
      o_id_in = o_id_ff; o_len_in = o_len_ff; o_count_in = o_count_ff;
      o_total_in = o_total_ff; o_mode_in = o_mode_ff; o_last_in = o_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = opcode_type'(req.opcode);
               id_in   = req.frag_id;
               dlen_in = req.data_len;
               sel_in  = req.slot_sel;
               now_in  = req.time_now;
               sidx_in = (opcode_type'(req.opcode) == OP_PUSH ||
                          opcode_type'(req.opcode) == OP_DELETE) ? '0 : SW'(req.slot_sel);
               found_coll_in = 1'b0;
               found_free_in = 1'b0;
               evict_in   = 1'b0;
               slot_ok_in = 1'b1;
            end
         end
         // Walk the slots: same-file collecting slot, lowest free, oldest
         ST_SCAN: begin
            if (!found_coll_ff && cur_mode == MODE_COLLECT && file_ff[sidx_ff] == id_ff[7:0]) begin
               found_coll_in = 1'b1;
               coll_in = sidx_ff;
            end
            if (!found_free_ff && cur_mode == MODE_FREE) begin
               found_free_in = 1'b1;
               free_in = sidx_ff;
            end
            if (sidx_ff == '0 || time_ff[sidx_ff] < besttime_ff) begin
               best_in = sidx_ff;
               besttime_in = time_ff[sidx_ff];
            end
            if (!sidx_last) sidx_in = sidx_ff + SW'(1);
         end
         ST_PICK: begin
            if (found_coll_ff) begin
               sidx_in = coll_ff;
            end else if (op_ff == OP_PUSH) begin
               sidx_in  = found_free_ff ? free_ff : best_ff;
               evict_in = !found_free_ff;
            end else begin
               slot_ok_in = 1'b0;
               status_in  = STS_NOTFOUND;
            end
         end
         // Evict or open the slot, or load its count, then start the entry walk
         ST_CLAIM: begin
            k_in = '0;
            vld_in = 1'b0;
            if (claim_new) begin
               mode_in[sidx_ff] = MODE_COLLECT;
               file_in[sidx_ff] = id_ff[7:0];
               cnt_in[sidx_ff]  = '0;
               if (evict_ff) begin
                  time_in[sidx_ff] = '0;
                  len_in[sidx_ff]  = 32'(header_len);
               end
               n_in = '0;
            end else begin
               n_in = cur_cnt;
            end
            pos_in = '0;
            if ((claim_new || cur_cnt == '0) && op_ff == OP_DELETE) status_in = STS_NOTFOUND;
         end
         // Ascending search, one read issued per cycle
         ST_SRCH: begin
            if (k_ff < n_ff) begin
               tag_in = k_ff;
               k_in   = k_ff + CW'(1);
               vld_in = 1'b1;
            end else begin
               vld_in = 1'b0;
            end
            if (rd_eq) begin
               vld_in = 1'b0;
               if (op_ff == OP_PUSH) begin
                  status_in = STS_DUP;
               end else begin
                  pos_in = tag_ff;
                  k_in   = tag_ff + CW'(1);
                  len_in[sidx_ff] = len_ff[sidx_ff] - (32'(item_overhead) + 32'(mem_rdata.len));
               end
            end else if (rd_gt || rd_end) begin
               vld_in = 1'b0;
               pos_in = rd_gt ? tag_ff : n_ff;
               if (op_ff == OP_DELETE) status_in = STS_NOTFOUND;
            end
         end
         ST_INS_CHK: begin
            k_in = n_ff;
            vld_in = 1'b0;
            if (n_ff >= CW'(ENTRIES)) status_in = STS_FULL;
         end
         // Move entries up by one, top first
         ST_INS_SHIFT: begin
            mem_wr.en = vld_ff;
            mem_raddr = base + AW'(k_ff - CW'(1));
            if (k_ff > pos_ff) begin
               tag_in = k_ff;
               k_in   = k_ff - CW'(1);
               vld_in = 1'b1;
            end else begin
               vld_in = 1'b0;
            end
         end
         ST_INS_WR: begin
            mem_wr.en      = 1'b1;
            mem_wr.data.id = id_ff;
            mem_wr.data.len = dlen_ff;
            mem_waddr      = base + AW'(pos_ff);
            cnt_in[sidx_ff]  = new_cnt;
            len_in[sidx_ff]  = len_ff[sidx_ff] + 32'(item_overhead) + 32'(dlen_ff);
            time_in[sidx_ff] = now_ff;
            if (id_ff[23:16] == 8'd1 && (9'(id_ff[15:8]) + 9'd1) == 9'(new_cnt)) begin
               mode_in[sidx_ff] = MODE_DONE;
            end
            status_in = STS_OK;
         end
         // Move entries down by one over the deleted place
         ST_DEL_SHIFT: begin
            mem_wr.en = vld_ff;
            if (k_ff < n_ff) begin
               tag_in = k_ff - CW'(1);
               k_in   = k_ff + CW'(1);
               vld_in = 1'b1;
            end else begin
               vld_in = 1'b0;
               cnt_in[sidx_ff] = n_ff - CW'(1);
               status_in = STS_OK;
            end
         end
         ST_SEL: begin
            slot_ok_in = sel_valid;
            k_in = '0;
            n_in = cur_cnt;
            if (!sel_valid) begin
               status_in = STS_NOTFOUND;
            end else if (op_ff == OP_FLUSH && cur_mode != MODE_DONE) begin
               status_in = STS_INCOMPLETE;
            end else begin
               status_in = STS_OK;
               mode_in[sidx_ff] = MODE_FREE;
               file_in[sidx_ff] = '0;
               time_in[sidx_ff] = '0;
               cnt_in[sidx_ff]  = '0;
               len_in[sidx_ff]  = 32'(header_len);
            end
         end
         ST_FL_EMIT: begin
            if (out_free) begin
               ovld_in      = 1'b1;
               o_status_in  = STS_FLUSHED;
               o_slot_in    = 2'(sidx_ff);
               o_evicted_in = 1'b0;
               o_id_in      = mem_rdata.id;
               o_len_in     = mem_rdata.len;
               o_count_in   = 6'(cur_cnt);
               o_total_in   = len_ff[sidx_ff];
               o_mode_in    = cur_mode;
               o_last_in    = (k_ff + CW'(1) == n_ff);
               k_in         = k_ff + CW'(1);
            end
         end
         ST_RESP: begin
            if (out_free) begin
               ovld_in      = 1'b1;
               o_status_in  = status_ff;
               o_slot_in    = slot_ok_ff ? 2'(sidx_ff) : 2'd0;
               o_evicted_in = evict_ff;
               o_id_in      = '0;
               o_len_in     = '0;
               o_count_in   = slot_ok_ff ? 6'(cur_cnt) : 6'd0;
               o_total_in   = slot_ok_ff ? len_ff[sidx_ff] : 32'd0;
               o_mode_in    = slot_ok_ff ? cur_mode : MODE_FREE;
               o_last_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovld_ff  <= 1'b0;
         vld_ff   <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            mode_ff[i] <= MODE_FREE;
            file_ff[i] <= '0;
            time_ff[i] <= '0;
            cnt_ff[i]  <= '0;
            len_ff[i]  <= 32'(HEADER_LEN_RESET);
         end
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         vld_ff   <= vld_in;
         mode_ff  <= mode_in;
         file_ff  <= file_in;
         time_ff  <= time_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; id_ff <= id_in; dlen_ff <= dlen_in; sel_ff <= sel_in; now_ff <= now_in;
      sidx_ff <= sidx_in; coll_ff <= coll_in; free_ff <= free_in; best_ff <= best_in;
      found_coll_ff <= found_coll_in; found_free_ff <= found_free_in;
      besttime_ff <= besttime_in; evict_ff <= evict_in; slot_ok_ff <= slot_ok_in;
      status_ff <= status_in;
      n_ff <= n_in; k_ff <= k_in; pos_ff <= pos_in; tag_ff <= tag_in;
      o_status_ff <= o_status_in; o_slot_ff <= o_slot_in; o_evicted_ff <= o_evicted_in;
      o_id_ff <= o_id_in; o_len_ff <= o_len_in; o_count_ff <= o_count_in;
      o_total_ff <= o_total_in; o_mode_ff <= o_mode_in; o_last_ff <= o_last_in;
   end

   assign rsp.valid      = ovld_ff;
   assign rsp.status     = o_status_ff;
   assign rsp.slot       = o_slot_ff;
   assign rsp.evicted    = o_evicted_ff;
   assign rsp.entry_id   = o_id_ff;
   assign rsp.entry_len  = o_len_ff;
   assign rsp.list_count = o_count_ff;
   assign rsp.msg_total  = o_total_ff;
   assign rsp.slot_mode  = o_mode_ff;
   assign rsp.last       = o_last_ff;

   `FRA_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req.ready)
   `FRA_ASSERT_IMPL(a_count_bound, clock, reset, state_ff == ST_INS_WR, n_ff < CW'(ENTRIES))
   `FRA_ASSERT_IMPL(a_flush_frees, clock, reset, ovld_ff && o_status_ff == STS_FLUSHED, o_mode_ff == MODE_FREE)
   `FRA_ASSERT_IMPL(a_write_phase, clock, reset, mem_wr.en, state_ff == ST_INS_SHIFT || state_ff == ST_INS_WR || state_ff == ST_DEL_SHIFT)

endmodule
`default_nettype wire

>>> hdl/fragment_reassembly_table.sv
`default_nettype none
// Channel   Direction  Handshake      Payload
// req_chan  in         valid/ready    opcode, frag_id, data_len, slot_sel, time_now
// rsp_chan  out        valid/ready    status, slot, evicted, entry_id, entry_len,
//                                     list_count, msg_total, slot_mode, last
// csr_*     in         csr_we         csr_index, csr_wdata
//
// One transaction at a time; req_chan.ready is high only while idle.
// Push/delete: slot scan, slot pick and claim, search and shift on the fragment
// store, then the response. Flush: select, then a read and an emit per fragment;
// clear or a rejected flush: select, then the response.
// Synchronous active-high reset, no clearing pass; the response register
// holds under rsp_chan.ready low while the next transaction may be taken.
module fragment_reassembly_table import fra_pkg::*; #(
   parameter int SLOTS = 4,
   parameter int ENTRIES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fra_req_if.sink          req_chan,
   fra_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int AW = $clog2(SLOTS * ENTRIES);

   logic [15:0]   header_len_ff, header_len_in;
   logic [15:0]   item_overhead_ff, item_overhead_in;
   mem_wr_type    mem_wr;
   logic [AW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_rdata;

   // Decode configuration writes
   always_comb begin
      header_len_in    = header_len_ff;
      item_overhead_in = item_overhead_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HEADER_LEN:    header_len_in    = csr_wdata;
            CSR_ITEM_OVERHEAD: item_overhead_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_len_ff    <= HEADER_LEN_RESET;
         item_overhead_ff <= ITEM_OVERHEAD_RESET;
      end else begin
         header_len_ff    <= header_len_in;
         item_overhead_ff <= item_overhead_in;
      end
   end

   fra_ctrl #(.SLOTS(SLOTS), .ENTRIES(ENTRIES)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .header_len    (header_len_ff),
      .item_overhead (item_overhead_ff),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .mem_wr        (mem_wr),
      .mem_waddr     (mem_waddr),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata)
   );

   fra_entry_mem #(.SLOTS(SLOTS), .ENTRIES(ENTRIES)) u_mem (
      .clock   (clock),
      .mem_wr  (mem_wr),
      .wr_addr (mem_waddr),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule
`default_nettype wire
